### rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// Shared widths, command and status codes, and controller/datapath links
// for the bounded shift-insert list.
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 7;
    localparam int VAL_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int FIDX_W    = 6;
    localparam int COUNT_W   = 7;

    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic load;
        logic check;
        logic walk;
        logic rd_first;
        logic rd_last;
        logic cap_last;
        logic emit;
    } sil_ctl_t;

    typedef struct packed {
        logic err;
        logic walk_done;
        logic out_free;
    } sil_sts_t;

endpackage

`default_nettype wire

### rtl/sil_if.sv
// ----------------------------------------------------------------------------
// sil_req_if / sil_rsp_if
// Valid/ready channels carrying list commands and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sil_req_if
    import sil_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, cmd, index, value, input ready);
    modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface sil_rsp_if
    import sil_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] read_value;
    logic [FIDX_W-1:0]       found_index;
    logic [COUNT_W-1:0]      entry_count;
    logic                    is_empty;
    logic signed [VAL_W-1:0] first_value;
    logic signed [VAL_W-1:0] last_value;

    modport source (output valid, status, read_value, found_index, entry_count,
                    is_empty, first_value, last_value, input ready);
    modport sink   (input valid, status, read_value, found_index, entry_count,
                    is_empty, first_value, last_value, output ready);
endinterface

`default_nettype wire

### rtl/sil_ctrl.sv
// ----------------------------------------------------------------------------
// sil_ctrl
// Sequencer for one request: check, walk the entry memory (skipped when the
// request is rejected), fetch the end entries, then hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_ctrl
    import sil_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire sil_sts_t sts,
    output sil_ctl_t      ctl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_FIRST = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;
    localparam logic [2:0] S_CAP   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.check  = 1'b1;
                state_next = sts.err ? S_FIRST : S_WALK;
            end
            S_WALK:
            begin
                ctl.walk = 1'b1;
                if (sts.walk_done)
                begin
                    state_next = S_FIRST;
                end
            end
            S_FIRST:
            begin
                ctl.rd_first = 1'b1;
                state_next   = S_LAST;
            end
            S_LAST:
            begin
                ctl.rd_last = 1'b1;
                state_next  = S_CAP;
            end
            S_CAP:
            begin
                ctl.cap_last = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                ctl.emit = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### rtl/sil_datapath.sv
// ----------------------------------------------------------------------------
// sil_datapath
// Entry memory, count, walk pointer with shift/compare logic, and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_datapath
    import sil_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire sil_ctl_t                ctl,
    output sil_sts_t                     sts,
    input  wire logic [CMD_W-1:0]        req_cmd,
    input  wire logic [IDX_W-1:0]        req_index,
    input  wire logic signed [VAL_W-1:0] req_value,
    output logic                         rsp_valid,
    input  wire logic                    rsp_ready,
    output logic [STATUS_W-1:0]          rsp_status,
    output logic signed [VAL_W-1:0]      rsp_read_value,
    output logic [FIDX_W-1:0]            rsp_found_index,
    output logic [COUNT_W-1:0]           rsp_entry_count,
    output logic                         rsp_is_empty,
    output logic signed [VAL_W-1:0]      rsp_first_value,
    output logic signed [VAL_W-1:0]      rsp_last_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    logic [VAL_W-1:0] mem [CAPACITY];
    logic [VAL_W-1:0] rdata_reg;

    logic [CMD_W-1:0]    cmd_reg,    cmd_next;
    logic [IDX_W-1:0]    idx_reg,    idx_next;
    logic [VAL_W-1:0]    val_reg,    val_next;
    logic [CW-1:0]       cnt_reg,    cnt_next;
    logic [CW-1:0]       ptr_reg,    ptr_next;
    logic [AW-1:0]       aprev_reg,  aprev_next;
    logic                rv_reg,     rv_next;
    logic                hit_reg,    hit_next;
    logic [VAL_W-1:0]    carry_reg,  carry_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]    rd_reg,     rd_next;
    logic [FIDX_W-1:0]   found_reg,  found_next;
    logic [VAL_W-1:0]    first_reg,  first_next;
    logic [VAL_W-1:0]    last_reg,   last_next;
    logic                ovalid_reg, ovalid_next;

    logic [STATUS_W-1:0] ostatus_reg;
    logic [VAL_W-1:0]    oread_reg;
    logic [FIDX_W-1:0]   ofound_reg;
    logic [COUNT_W-1:0]  ocount_reg;
    logic                oempty_reg;
    logic [VAL_W-1:0]    ofirst_reg;
    logic [VAL_W-1:0]    olast_reg;

    logic [XW-1:0]       idx_x;
    logic [XW-1:0]       cnt_x;
    logic [XW-1:0]       ptr_x;
    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       start_ptr;
    logic [STATUS_W-1:0] chk_status;
    logic                err;
    logic                more;
    logic                hit_now;
    logic                issue;
    logic                walk_done;
    logic                mem_we;
    logic [AW-1:0]       waddr;
    logic [VAL_W-1:0]    wdata;
    logic [AW-1:0]       raddr;
    logic                out_free;
    logic                out_load;

    always_comb
    begin
        idx_x     = XW'(idx_reg);
        cnt_x     = XW'(cnt_reg);
        ptr_x     = XW'(ptr_reg);
        cnt_m1    = cnt_reg - CW'(1);
        err        = 1'b0;
        chk_status = ST_OK;
        start_ptr  = CW'(idx_reg);
        more       = 1'b0;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (idx_x > cnt_x)
                begin
                    err        = 1'b1;
                    chk_status = ST_RANGE;
                end
                else if (cnt_reg == CW'(CAPACITY))
                begin
                    err        = 1'b1;
                    chk_status = ST_FULL;
                end
                more = (ptr_reg <= cnt_reg);
            end
            CMD_ERASE:
            begin
                if (idx_x >= cnt_x)
                begin
                    err        = 1'b1;
                    chk_status = ST_RANGE;
                end
                start_ptr = CW'(idx_reg) + CW'(1);
                more      = (ptr_reg < cnt_reg);
            end
            CMD_READ:
            begin
                if (idx_x >= cnt_x)
                begin
                    err        = 1'b1;
                    chk_status = ST_RANGE;
                end
                more = (ptr_x == idx_x);
            end
            default:
            begin
                chk_status = ST_NOTFOUND;
                start_ptr  = '0;
                more       = (ptr_reg < cnt_reg) && !hit_reg
                             && !(rv_reg && (rdata_reg == val_reg));
            end
        endcase
        hit_now   = (cmd_reg == CMD_SEARCH) && rv_reg && !hit_reg
                    && (rdata_reg == val_reg);
        issue     = ctl.walk && more;
        walk_done = !rv_reg && !more;

        mem_we = ctl.walk && rv_reg
                 && ((cmd_reg == CMD_INSERT) || (cmd_reg == CMD_ERASE));
        if (cmd_reg == CMD_INSERT)
        begin
            waddr = aprev_reg;
            wdata = carry_reg;
        end
        else
        begin
            waddr = aprev_reg - AW'(1);
            wdata = rdata_reg;
        end

        if (ctl.rd_first)
        begin
            raddr = '0;
        end
        else if (ctl.rd_last)
        begin
            raddr = cnt_m1[AW-1:0];
        end
        else
        begin
            raddr = ptr_reg[AW-1:0];
        end

        out_free = !ovalid_reg || rsp_ready;
        out_load = ctl.emit && out_free;
    end

    always_comb
    begin
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        aprev_next  = aprev_reg;
        rv_next     = rv_reg;
        hit_next    = hit_reg;
        carry_next  = carry_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        found_next  = found_reg;
        first_next  = first_reg;
        last_next   = last_reg;

        if (ctl.load)
        begin
            cmd_next = req_cmd;
            idx_next = req_index;
            val_next = req_value;
        end
        if (ctl.check)
        begin
            status_next = chk_status;
            rd_next     = '0;
            found_next  = '0;
            hit_next    = 1'b0;
            rv_next     = 1'b0;
            carry_next  = val_reg;
            ptr_next    = start_ptr;
        end
        if (ctl.walk)
        begin
            rv_next = issue;
            if (issue)
            begin
                aprev_next = ptr_reg[AW-1:0];
                ptr_next   = ptr_reg + CW'(1);
            end
            if (rv_reg && (cmd_reg == CMD_INSERT))
            begin
                carry_next = rdata_reg;
            end
            if (rv_reg && (cmd_reg == CMD_READ))
            begin
                rd_next = rdata_reg;
            end
            if (hit_now)
            begin
                found_next  = FIDX_W'(aprev_reg);
                hit_next    = 1'b1;
                status_next = ST_OK;
            end
            if (walk_done && (cmd_reg == CMD_INSERT))
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else if (walk_done && (cmd_reg == CMD_ERASE))
            begin
                cnt_next = cnt_m1;
            end
        end
        if (ctl.rd_last)
        begin
            first_next = rdata_reg;
        end
        if (ctl.cap_last)
        begin
            last_next = rdata_reg;
        end

        ovalid_next = out_load || (ovalid_reg && !rsp_ready);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            rv_reg     <= 1'b0;
            hit_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            rv_reg     <= rv_next;
            hit_reg    <= hit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        ptr_reg    <= ptr_next;
        aprev_reg  <= aprev_next;
        carry_reg  <= carry_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        if (out_load)
        begin
            ostatus_reg <= status_reg;
            oread_reg   <= rd_reg;
            ofound_reg  <= found_reg;
            ocount_reg  <= COUNT_W'(cnt_reg);
            oempty_reg  <= (cnt_reg == '0);
            ofirst_reg  <= (cnt_reg == '0) ? '0 : first_reg;
            olast_reg   <= (cnt_reg == '0) ? '0 : last_reg;
        end
    end

    assign rsp_valid       = ovalid_reg;
    assign rsp_status      = ostatus_reg;
    assign rsp_read_value  = oread_reg;
    assign rsp_found_index = ofound_reg;
    assign rsp_entry_count = ocount_reg;
    assign rsp_is_empty    = oempty_reg;
    assign rsp_first_value = ofirst_reg;
    assign rsp_last_value  = olast_reg;

    assign sts.err       = err;
    assign sts.walk_done = walk_done;
    assign sts.out_free  = out_free;

endmodule

`default_nettype wire

### rtl/shift_insert_list.sv
// ----------------------------------------------------------------------------
// shift_insert_list
// Bounded ordered list of signed 64-bit values with insert, erase, read and
// search requests.
// ----------------------------------------------------------------------------
// One request at a time. Entries live in a single-port-write, registered-read
// memory, and insert, erase and search walk it one entry per cycle. The walk
// visits count-index+1 entries for insert, count-index-1 for erase, up to and
// including the first match or all count entries for search, and one for read.
// A rejected request (full list or index out of range) skips the walk. Two
// extra memory reads fetch the first and last entries for every result.
// A finished result sits in an output register while the next request may be
// presented; the next request is taken once the result has been loaded there,
// and a result still waiting in that register holds the block until it drains.
`default_nettype none

module shift_insert_list
    import sil_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sil_req_if.sink    req,
    sil_rsp_if.source  rsp
);

    sil_ctl_t ctl;
    sil_sts_t sts;

    sil_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    sil_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .req_cmd         (req.cmd),
        .req_index       (req.index),
        .req_value       (req.value),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_status      (rsp.status),
        .rsp_read_value  (rsp.read_value),
        .rsp_found_index (rsp.found_index),
        .rsp_entry_count (rsp.entry_count),
        .rsp_is_empty    (rsp.is_empty),
        .rsp_first_value (rsp.first_value),
        .rsp_last_value  (rsp.last_value)
    );

endmodule

`default_nettype wire

### rtl/sil_checker.sv
// ----------------------------------------------------------------------------
// sil_checker
// Port-level checks on the list block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module sil_checker
    import sil_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                req_valid,
    input wire logic                req_ready,
    input wire logic                rsp_valid,
    input wire logic                rsp_ready,
    input wire logic [STATUS_W-1:0] rsp_status,
    input wire logic [VAL_W-1:0]    rsp_read_value,
    input wire logic [FIDX_W-1:0]   rsp_found_index,
    input wire logic [COUNT_W-1:0]  rsp_entry_count,
    input wire logic                rsp_is_empty,
    input wire logic [VAL_W-1:0]    rsp_first_value,
    input wire logic [VAL_W-1:0]    rsp_last_value
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_read_value) && $stable(rsp_entry_count))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_is_empty == (rsp_entry_count == '0))
        else $error("empty flag disagrees with entry count");

    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_empty |-> rsp_first_value == '0
            && rsp_last_value == '0)
        else $error("end values not zero on empty list");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_read_value == '0
            && rsp_found_index == '0)
        else $error("read value or found index set on failed request");

endmodule

bind shift_insert_list sil_checker u_sil_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_read_value  (rsp.read_value),
    .rsp_found_index (rsp.found_index),
    .rsp_entry_count (rsp.entry_count),
    .rsp_is_empty    (rsp.is_empty),
    .rsp_first_value (rsp.first_value),
    .rsp_last_value  (rsp.last_value)
);

`default_nettype wire

### sim/list_checker.sv
// ----------------------------------------------------------------------------
// list_checker
// Watches the request and result channels of the shift-insert list, keeps its
// own copy of the list, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module list_checker
    import sil_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    sil_req_if   req,
    sil_rsp_if   rsp,
    output int   errors,
    output int   outstanding,
    output int   checked,
    output int   full_hits,
    output int   peak_len
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP = DEFAULT_CAPACITY;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] read_value;
        logic [FIDX_W-1:0]       found_index;
        logic [COUNT_W-1:0]      entry_count;
        logic                    is_empty;
        logic signed [VAL_W-1:0] first_value;
        logic signed [VAL_W-1:0] last_value;
    } list_result_t;

    logic signed [VAL_W-1:0] list_mem [0:LIST_CAP-1];
    int unsigned             list_len = 0;
    list_result_t            pending_q [$];
    int                      err_count = 0;
    int                      check_count = 0;
    int                      full_count = 0;
    int unsigned             longest = 0;

    function automatic void apply_request(
        input  logic [CMD_W-1:0]        op,
        input  logic [IDX_W-1:0]        pos,
        input  logic signed [VAL_W-1:0] val,
        output list_result_t            res
    );
        int unsigned j;
        bit          hit;
        res = '0;
        res.status = ST_OK;
        hit = 1'b0;
        case (op)
            CMD_INSERT:
            begin
                if (pos > list_len)
                    res.status = ST_RANGE;
                else if (list_len >= LIST_CAP)
                    res.status = ST_FULL;
                else
                begin
                    for (j = list_len; j > pos; j--)
                        list_mem[j] = list_mem[j - 1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            CMD_ERASE:
            begin
                if (pos >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (j = pos + 1; j < list_len; j++)
                        list_mem[j - 1] = list_mem[j];
                    list_len--;
                end
            end
            CMD_READ:
            begin
                if (pos >= list_len)
                    res.status = ST_RANGE;
                else
                    res.read_value = list_mem[pos];
            end
            default:
            begin
                res.status = ST_NOTFOUND;
                for (j = 0; j < list_len && !hit; j++)
                begin
                    if (list_mem[j] == val)
                    begin
                        hit = 1'b1;
                        res.status = ST_OK;
                        res.found_index = FIDX_W'(j);
                    end
                end
            end
        endcase
        res.entry_count = COUNT_W'(list_len);
        res.is_empty    = (list_len == 0);
        res.first_value = (list_len > 0) ? list_mem[0] : '0;
        res.last_value  = (list_len > 0) ? list_mem[list_len - 1] : '0;
    endfunction

    task automatic check_field(
        input string                   name,
        input logic signed [VAL_W-1:0] want,
        input logic signed [VAL_W-1:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_q.size() == 0)
                begin
                    $error("result with no request pending");
                    err_count++;
                end
                else
                begin
                    want = pending_q[0];
                    pending_q.delete(0);
                    check_field("status", VAL_W'(want.status), VAL_W'(rsp.status));
                    check_field("read_value", want.read_value, rsp.read_value);
                    check_field("found_index", VAL_W'(want.found_index),
                                VAL_W'(rsp.found_index));
                    check_field("entry_count", VAL_W'(want.entry_count),
                                VAL_W'(rsp.entry_count));
                    check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(rsp.is_empty));
                    check_field("first_value", want.first_value, rsp.first_value);
                    check_field("last_value", want.last_value, rsp.last_value);
                    check_count++;
                end
            end
            if (req.valid && req.ready)
            begin
                apply_request(req.cmd, req.index, req.value, want);
                if (want.status == ST_FULL)
                    full_count++;
                if (list_len > longest)
                    longest = list_len;
                pending_q = {pending_q, want};
            end
        end
        errors      <= err_count;
        outstanding <= pending_q.size();
        checked     <= check_count;
        full_hits   <= full_count;
        peak_len    <= longest;
    end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the shift-insert list with a directed opening and phased random
// requests that fill, churn and drain it, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import sil_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1380;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT        = 1000000;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;

    sil_req_if req ();
    sil_rsp_if rsp ();

    int          errors;
    int          outstanding;
    int          checked;
    int          full_hits;
    int          peak_len;

    int unsigned est_len = 0;
    int          op_count [0:3] = '{0, 0, 0, 0};
    bit          steady = 1'b0;
    bit          squeeze_pending = 1'b0;
    int          cycle_count = 0;

    logic signed [VAL_W-1:0] value_pool [0:15];

    shift_insert_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .full_hits   (full_hits),
        .peak_len    (peak_len)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send(
        input logic [CMD_W-1:0]        op,
        input logic [IDX_W-1:0]        pos,
        input logic signed [VAL_W-1:0] val
    );
        int unsigned r;
        int unsigned gap;
        req.valid <= 1'b1;
        req.cmd   <= op;
        req.index <= pos;
        req.value <= val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        op_count[op]++;
        if (op == CMD_INSERT && pos <= est_len && est_len < DEFAULT_CAPACITY)
            est_len++;
        else if (op == CMD_ERASE && pos < est_len)
            est_len--;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : result_side
        int unsigned r;
        int unsigned span;
        logic        level;
        rsp.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (squeeze_pending)
            begin
                squeeze_pending = 1'b0;
                level = 1'b0;
                span  = HOLD_CYCLES;
            end
            else if (steady)
            begin
                level = 1'b1;
                span  = 1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    level = 1'b1;
                    span  = $urandom_range(1, 8);
                end
                else if (r < 92)
                begin
                    level = 1'b0;
                    span  = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b0;
                    span  = $urandom_range(10, 40);
                end
            end
            rsp.ready <= level;
            repeat (span) @(posedge clk);
        end
    end

    initial
    begin : request_side
        int                      sent;
        int                      phase;
        int                      span;
        int unsigned             r;
        int unsigned             ins_w;
        int unsigned             era_w;
        int unsigned             rd_w;
        logic [CMD_W-1:0]        op;
        logic [IDX_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;

        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.cmd   = CMD_INSERT;
        req.index = '0;
        req.value = '0;
        for (int k = 0; k < 16; k++)
            value_pool[k] = (k < 4) ? VAL_W'(k) : {$urandom, $urandom};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(CMD_READ,   7'd0,   '0);
        send(CMD_ERASE,  7'd0,   '0);
        send(CMD_SEARCH, 7'd0,   '0);
        send(CMD_INSERT, 7'd1,   64'sd5);
        send(CMD_INSERT, 7'd0,   VAL_MIN);
        send(CMD_INSERT, 7'd1,   VAL_MAX);
        send(CMD_INSERT, 7'd0,   '0);
        send(CMD_INSERT, 7'd1,   -64'sd1);
        send(CMD_INSERT, 7'd4,   '0);
        send(CMD_READ,   7'd0,   '0);
        send(CMD_READ,   7'd4,   '1);
        send(CMD_READ,   7'd5,   '0);
        send(CMD_READ,   7'd127, '1);
        send(CMD_SEARCH, 7'd0,   '0);
        send(CMD_SEARCH, 7'd127, VAL_MAX);
        send(CMD_SEARCH, 7'd0,   64'sd1);
        send(CMD_SEARCH, 7'd0,   VAL_MIN);
        send(CMD_ERASE,  7'd5,   '0);
        send(CMD_ERASE,  7'd4,   '0);
        send(CMD_ERASE,  7'd0,   '0);
        send(CMD_ERASE,  7'd1,   '0);
        send(CMD_INSERT, 7'd127, 64'sd1);
        send(CMD_ERASE,  7'd1,   '0);
        send(CMD_ERASE,  7'd0,   '0);
        send(CMD_ERASE,  7'd0,   '0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (phase % 4 == 2);
            if (phase == 1)
                squeeze_pending = 1'b1;
            case (phase % 4)
                0:       begin ins_w = 85; era_w = 5;  rd_w = 5;  end
                3:       begin ins_w = 10; era_w = 65; rd_w = 15; end
                default: begin ins_w = 30; era_w = 25; rd_w = 20; end
            endcase
            span = $urandom_range(80, 160);
            for (int n = 0; n < span && sent < RANDOM_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < ins_w)
                    op = CMD_INSERT;
                else if (r < ins_w + era_w)
                    op = CMD_ERASE;
                else if (r < ins_w + era_w + rd_w)
                    op = CMD_READ;
                else
                    op = CMD_SEARCH;

                r = $urandom_range(0, 99);
                if (r < 25)
                    pos = IDX_W'(est_len);
                else if (r < 35)
                    pos = '0;
                else if (r < 50 && est_len > 0)
                    pos = IDX_W'(est_len - 1);
                else if (r < 92)
                    pos = IDX_W'($urandom_range(0, est_len));
                else
                    pos = IDX_W'($urandom_range(0, 127));

                r = $urandom_range(0, 99);
                if (op != CMD_INSERT && op != CMD_SEARCH)
                    val = {$urandom, $urandom};
                else if (r < 45)
                    val = value_pool[$urandom_range(0, 15)];
                else if (r < 60)
                begin
                    case ($urandom_range(0, 4))
                        0:       val = VAL_MIN;
                        1:       val = VAL_MAX;
                        2:       val = '0;
                        3:       val = -64'sd1;
                        default: val = 64'sd1;
                    endcase
                end
                else
                begin
                    val = {$urandom, $urandom};
                    value_pool[$urandom_range(0, 15)] = val;
                end

                send(op, pos, val);
                sent++;
            end
            phase++;
        end

        steady = 1'b0;
        req.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d insert, %0d erase, %0d read, %0d search.",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[CMD_INSERT], op_count[CMD_ERASE], op_count[CMD_READ],
                 op_count[CMD_SEARCH]);
        $display("%0d results checked, %0d hit a full list, list reached %0d entries.",
                 checked, full_hits, peak_len);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
